FILE: design/hapg_pkg.sv
// Shared types, constants and the control program of the hopalong point generator.
`timescale 1ns / 1ps

package hapg_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int EDGE_MARGIN = 3;

  localparam int COORD_W    = 32;
  localparam int PIX_W      = 24;
  localparam int CNT_W      = 24;
  localparam int MAG_W      = 11;
  localparam int CENTER_W   = 12;
  localparam int PROD_W     = 65;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int ITER_W     = $clog2(ROOT_STEPS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PC_W       = 4;

  localparam logic [COORD_W-1:0]  COEF_A_RST = 32'sd327680;
  localparam logic [COORD_W-1:0]  COEF_B_RST = 32'sd851968;
  localparam logic [COORD_W-1:0]  COEF_C_RST = 32'sd91750400;
  localparam logic [MAG_W-1:0]    MAG_RST    = 11'd1;
  localparam logic [CENTER_W-1:0] CENTER_RST = 12'd400;
  localparam logic [CNT_W-1:0]    LIMIT_RST  = 24'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A        = 3'd0,
    REG_COEF_B        = 3'd1,
    REG_COEF_C        = 3'd2,
    REG_MAGNIFICATION = 3'd3,
    REG_SCREEN_CENTER = 3'd4,
    REG_POINT_LIMIT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_X_MAG = 2'd0,
    MUL_Y_MAG = 2'd1,
    MUL_B_X   = 2'd2
  } mul_sel_e;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_WAIT_IN    = 3'd1,
    C_WAIT_OUT   = 3'd2,
    C_WAIT_ROOT  = 3'd3,
    C_BRANCH_END = 3'd4,
    C_JUMP       = 3'd5
  } cond_e;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_WAIT  = 4'd0;
  localparam pc_t STEP_CHECK = 4'd1;
  localparam pc_t STEP_PIX_X = 4'd2;
  localparam pc_t STEP_PIX_Y = 4'd3;
  localparam pc_t STEP_EMIT  = 4'd4;
  localparam pc_t STEP_DIFF  = 4'd5;
  localparam pc_t STEP_LOAD  = 4'd6;
  localparam pc_t STEP_ROOT  = 4'd7;
  localparam pc_t STEP_UPD   = 4'd8;

  typedef struct packed {
    logic     in_ready;
    mul_sel_e mul_sel;
    logic     pix_x_ld;
    logic     pix_y_ld;
    logic     emit;
    logic     diff_ld;
    logic     root_ld;
    logic     root_en;
    logic     upd;
    cond_e    cond;
    pc_t      target;
  } ucode_t;

  typedef struct packed {
    logic     in_ready;
    logic     accept;
    mul_sel_e mul_sel;
    logic     pix_x_ld;
    logic     pix_y_ld;
    logic     emit;
    logic     diff_ld;
    logic     root_ld;
    logic     root_en;
    logic     upd;
  } ctrl_t;

  typedef struct packed {
    logic limit_hit;
    logic root_done;
    logic out_free;
  } status_t;

  function automatic ucode_t hapg_ucode(pc_t pc);
    ucode_t w;
    w = '{in_ready: 1'b0, mul_sel: MUL_X_MAG, pix_x_ld: 1'b0, pix_y_ld: 1'b0,
          emit: 1'b0, diff_ld: 1'b0, root_ld: 1'b0, root_en: 1'b0, upd: 1'b0,
          cond: C_NEXT, target: STEP_WAIT};
    case (pc)
      STEP_WAIT: begin
        w.in_ready = 1'b1;
        w.cond     = C_WAIT_IN;
      end
      STEP_CHECK: begin
        w.mul_sel = MUL_X_MAG;
        w.cond    = C_BRANCH_END;
        w.target  = STEP_WAIT;
      end
      STEP_PIX_X: begin
        w.mul_sel  = MUL_Y_MAG;
        w.pix_x_ld = 1'b1;
      end
      STEP_PIX_Y: begin
        w.mul_sel  = MUL_B_X;
        w.pix_y_ld = 1'b1;
      end
      STEP_EMIT: begin
        w.mul_sel = MUL_B_X;
        w.emit    = 1'b1;
        w.cond    = C_WAIT_OUT;
      end
      STEP_DIFF: begin
        w.diff_ld = 1'b1;
      end
      STEP_LOAD: begin
        w.root_ld = 1'b1;
      end
      STEP_ROOT: begin
        w.root_en = 1'b1;
        w.cond    = C_WAIT_ROOT;
      end
      STEP_UPD: begin
        w.upd    = 1'b1;
        w.cond   = C_JUMP;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/hapg_sequencer.sv
// Step counter and control-program decode of the hopalong point generator.
`timescale 1ns / 1ps

module hapg_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  hapg_pkg::status_t status_i,
  output hapg_pkg::ctrl_t   ctrl_o
);
  import hapg_pkg::*;

  pc_t    pc_q, pc_d;
  ucode_t uc;

  assign uc = hapg_ucode(pc_q);

  always_comb begin
    pc_d = pc_q;
    case (uc.cond)
      C_NEXT:       pc_d = pc_q + pc_t'(1);
      C_WAIT_IN:    if (in_valid_i) pc_d = pc_q + pc_t'(1);
      C_WAIT_OUT:   if (status_i.out_free) pc_d = pc_q + pc_t'(1);
      C_WAIT_ROOT:  if (status_i.root_done) pc_d = pc_q + pc_t'(1);
      C_BRANCH_END: pc_d = status_i.limit_hit ? uc.target : pc_q + pc_t'(1);
      C_JUMP:       pc_d = uc.target;
      default:      pc_d = STEP_WAIT;
    endcase
  end

  always_comb begin
    ctrl_o.in_ready = uc.in_ready;
    ctrl_o.accept   = uc.in_ready & in_valid_i;
    ctrl_o.mul_sel  = uc.mul_sel;
    ctrl_o.pix_x_ld = uc.pix_x_ld;
    ctrl_o.pix_y_ld = uc.pix_y_ld;
    ctrl_o.emit     = uc.emit & status_i.out_free;
    ctrl_o.diff_ld  = uc.diff_ld;
    ctrl_o.root_ld  = uc.root_ld;
    ctrl_o.root_en  = uc.root_en & ~status_i.root_done;
    ctrl_o.upd      = uc.upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: design/hapg_root_unit.sv
// Bit-serial integer square root, one result bit per cycle while enabled.
`timescale 1ns / 1ps

module hapg_root_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          en_i,
  input  logic [hapg_pkg::RAD_W-1:0]    rad_i,
  output logic [hapg_pkg::ROOT_W-1:0]   root_o,
  output logic                          done_o
);
  import hapg_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ITER_W-1:0] left_q, left_d;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    left_d = left_q;
    if (load_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      left_d = ITER_W'(ROOT_STEPS);
    end else if (en_i) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      left_d = left_q - ITER_W'(1);
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = (left_q == '0);

endmodule

FILE: design/hapg_datapath.sv
// Configuration, point state, shared multiplier and output register of the generator.
`timescale 1ns / 1ps

module hapg_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hapg_pkg::ctrl_t                   ctrl_i,
  output hapg_pkg::status_t                 status_o,
  input  logic                              cfg_we_i,
  input  logic [hapg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hapg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              restart_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [hapg_pkg::PIX_W-1:0]        pixel_x_o,
  output logic [hapg_pkg::PIX_W-1:0]        pixel_y_o,
  output logic                              last_point_o
);
  import hapg_pkg::*;

  localparam int Q_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W = Q_W + 2;
  localparam int EXT_W = COORD_W + 2;

  function automatic logic [PIX_W-1:0] to_pixel(logic signed [PROD_W-1:0] prod,
                                                 logic [CENTER_W-1:0] ctr);
    logic signed [Q_W-1:0]   q;
    logic signed [SUM_W-1:0] s;
    q = prod[PROD_W-1:FRAC_BITS];
    if (prod[PROD_W-1] && (|prod[FRAC_BITS-1:0])) q = q + Q_W'(1);
    s = SUM_W'(q) + $signed(SUM_W'(ctr)) + $signed(SUM_W'(EDGE_MARGIN));
    if (s > $signed(SUM_W'(2 ** (PIX_W - 1) - 1))) begin
      return {1'b0, {(PIX_W-1){1'b1}}};
    end else if (s < -$signed(SUM_W'(2 ** (PIX_W - 1)))) begin
      return {1'b1, {(PIX_W-1){1'b0}}};
    end
    return s[PIX_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] sat_coord(logic signed [EXT_W-1:0] v);
    if (v > $signed({{(EXT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}})) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < $signed({{(EXT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}})) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return v[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic [MAG_W-1:0]          mag_q;
  logic [CENTER_W-1:0]       center_q;
  logic [CNT_W-1:0]          limit_q;

  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic signed [COORD_W-1:0] op_a;
  logic signed [COORD_W:0]   op_b;
  logic signed [PROD_W-1:0]  product_q, product_d;
  logic signed [PROD_W-1:0]  diff_q;
  logic [RAD_W-1:0]          rad;
  logic [PIX_W-1:0]          pix_x_q, pix_y_q;

  logic                      out_valid_q;
  logic [PIX_W-1:0]          out_x_q, out_y_q;
  logic                      out_last_q;
  logic                      last_now;

  logic [ROOT_W-1:0]         root;
  logic                      root_done;
  logic signed [EXT_W-1:0]   nx, ny;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= COEF_A_RST;
      coef_b_q <= COEF_B_RST;
      coef_c_q <= COEF_C_RST;
      mag_q    <= MAG_RST;
      center_q <= CENTER_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_A:        coef_a_q <= cfg_data_i[COORD_W-1:0];
        REG_COEF_B:        coef_b_q <= cfg_data_i[COORD_W-1:0];
        REG_COEF_C:        coef_c_q <= cfg_data_i[COORD_W-1:0];
        REG_MAGNIFICATION: mag_q    <= cfg_data_i[MAG_W-1:0];
        REG_SCREEN_CENTER: center_q <= cfg_data_i[CENTER_W-1:0];
        REG_POINT_LIMIT:   limit_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_Y_MAG: begin
        op_a = y_q;
        op_b = $signed((COORD_W + 1)'(mag_q));
      end
      MUL_B_X: begin
        op_a = x_q;
        op_b = (COORD_W + 1)'(coef_b_q);
      end
      default: begin
        op_a = x_q;
        op_b = $signed((COORD_W + 1)'(mag_q));
      end
    endcase
    product_d = op_a * op_b;
  end

  assign rad = diff_q[PROD_W-1] ? RAD_W'(-diff_q) : RAD_W'(diff_q);

  hapg_root_unit u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctrl_i.root_ld),
    .en_i   (ctrl_i.root_en),
    .rad_i  (rad),
    .root_o (root),
    .done_o (root_done)
  );

  always_comb begin
    if (x_q[COORD_W-1]) begin
      nx = EXT_W'(y_q) + $signed(EXT_W'(root));
    end else begin
      nx = EXT_W'(y_q) - $signed(EXT_W'(root));
    end
    ny = EXT_W'(coef_a_q) - EXT_W'(x_q);
  end

  assign last_now = ((CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(limit_q);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    cnt_d = cnt_q;
    if (ctrl_i.accept && restart_i) begin
      x_d   = '0;
      y_d   = '0;
      cnt_d = '0;
    end
    if (ctrl_i.emit) cnt_d = cnt_q + CNT_W'(1);
    if (ctrl_i.upd) begin
      x_d = sat_coord(nx);
      y_d = sat_coord(ny);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= '0;
      y_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      cnt_q <= cnt_d;
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
    if (ctrl_i.diff_ld) diff_q <= product_q - (PROD_W'(coef_c_q) <<< FRAC_BITS);
    if (ctrl_i.pix_x_ld) pix_x_q <= to_pixel(product_q, center_q);
    if (ctrl_i.pix_y_ld) pix_y_q <= to_pixel(product_q, center_q);
    if (ctrl_i.emit) begin
      out_x_q    <= pix_x_q;
      out_y_q    <= pix_y_q;
      out_last_q <= last_now;
    end
  end

  assign status_o.limit_hit = (cnt_q >= limit_q);
  assign status_o.root_done = root_done;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign last_point_o = out_last_q;

endmodule

FILE: design/hopalong_attractor_point_generator_top.sv
// Top level of the hopalong attractor point generator.
// Each request on the slave stream asks for one point; bit 0 of its data is restart, which
// returns the point to the origin and the count to zero first. While the count is below
// point_limit the request yields one result on the master stream (pixel x and y, tlast on the
// final point); otherwise it yields none. When the output is free the result is loaded into the
// output register in the emit step, which follows the limit check and the pixel x and y steps;
// the request occupies the block for 8 control steps plus the square root step, which resolves
// one bit per cycle until the root is done. A stalled output holds the request in the emit step
// until the output is free. A request that yields no result returns to waiting after the check.
// One request is worked on at a time; the next is taken while a result still waits in the
// output register. Configuration writes are taken at any cycle with no wait.
`timescale 1ns / 1ps

module hopalong_attractor_point_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [0] restart
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // [23:0] pixel_x, [47:24] pixel_y
  output logic                              m_axis_tlast,  // last_point
  input  logic                              cfg_we_i,
  input  logic [hapg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hapg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hapg_pkg::*;

  ctrl_t            ctrl;
  status_t          status;
  logic [PIX_W-1:0] pixel_x, pixel_y;

  hapg_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  hapg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .restart_i    (s_axis_tdata[0]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .last_point_o (m_axis_tlast)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tdata  = {pixel_y, pixel_x};

endmodule

FILE: design/hapg_checker.sv
// Port-level assertions for the hopalong point generator, bound to the top level.
`timescale 1ns / 1ps

module hapg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [47:0]                       m_axis_tdata,
  input logic                              m_axis_tlast
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_one_request_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  a_result_only_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a request in work");

endmodule

bind hopalong_attractor_point_generator_top hapg_checker u_checker (.*);
